>>> hw/rtl/pfa_pkg.sv
// Package for the partition fit allocator: shared codes, default sizes,
// controller state type and the command/status bundles between the units.
// No dependencies.
package pfa_pkg;

    // Default table geometry
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    // Fixed field widths of the stream words
    localparam int IDX_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 8;
    localparam int MODE_W       = 2;
    localparam int BCOUNT_W     = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;

    // Item kinds carried in s_axis_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Fit rules
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_WB
    } pfa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_we;
        logic alloc_start;
        logic scan_init;
        logic scan_step;
        logic wb_fire;
        logic cfg_we;
    } pfa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
    } pfa_status_t;

endpackage

>>> hw/rtl/partition_fit_allocator_top.sv
// Top level of the partition fit allocator: stream and config ports,
// controller and datapath. Depends on pfa_pkg, pfa_ctrl, pfa_datapath.
//
//   port group   dir  word contents
//   s_axis_*     in   tuser: cmd; tdata: block_index, block_size, request_size
//   m_axis_*     out  tuser: granted; tdata: chosen_block
//   cfg_*        in   cfg_index selects fit_mode or block_count; cfg_data value
//
// A load word is written into the table when taken. An allocate word runs
// a setup step, one table read and compare per entry in use, min(block_count,
// NUM_BLOCKS) of them, via the single registered read port, and a write-back.
// A finished result waits in the output register while the next word is
// taken; write-back of the following allocate stalls until that result goes.
// Reset (aresetn low, synchronous) sets first fit, block_count 16, rover 0;
// table entries hold nothing defined until loaded.
module partition_fit_allocator_top
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] block_index, [19:4] block_size, [35:20] request_size, [39:36] zero
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] chosen_block, [7:4] zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] granted
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pfa_cmd_t               cmd;
    pfa_status_t            status;
    logic [IDX_FIELD_W-1:0] chosen_block;

    pfa_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    pfa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_block_index   (s_axis_tdata[3:0]),
        .in_block_size    (s_axis_tdata[19:4]),
        .in_request_size  (s_axis_tdata[35:20]),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_granted      (m_axis_tuser),
        .out_chosen_block (chosen_block)
    );

    // Pad the result word to a whole byte
    assign m_axis_tdata = {{(M_TDATA_W - IDX_FIELD_W){1'b0}}, chosen_block};

endmodule

>>> hw/rtl/pfa_ctrl.sv
// Controller of the partition fit allocator: sequences accept, scan setup,
// table scan and write-back, and owns the result valid flag.
// Depends on pfa_pkg.
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tuser,
    output logic        s_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output pfa_cmd_t    cmd,
    input  pfa_status_t status
);

    pfa_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser == CMD_ALLOC) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = status.cnt_zero ? ST_WB : ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        cfg_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready   = 1'b1;
                cfg_ready       = 1'b1;
                cmd.cfg_we      = cfg_valid;
                cmd.load_we     = s_axis_tvalid && s_axis_tuser == CMD_LOAD;
                cmd.alloc_start = s_axis_tvalid && s_axis_tuser == CMD_ALLOC;
            end
            ST_START: begin
                cmd.scan_init = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_WB: begin
                cmd.wb_fire = !m_valid_reg || m_axis_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        if (cmd.wb_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

endmodule

>>> hw/rtl/pfa_datapath.sv
// Datapath of the partition fit allocator: free size table, config registers,
// rover, scan position, compare and pick registers, write-back and result word.
// Depends on pfa_pkg.
module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pfa_cmd_t                cmd,
    output pfa_status_t             status,
    input  logic [IDX_FIELD_W-1:0]  in_block_index,
    input  logic [SIZE_FIELD_W-1:0] in_block_size,
    input  logic [SIZE_FIELD_W-1:0] in_request_size,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    out_granted,
    output logic [IDX_FIELD_W-1:0]  out_chosen_block
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];

    logic [MODE_W-1:0]     mode_reg;
    logic [BCOUNT_W-1:0]   bcount_reg;
    logic [IDX_W-1:0]      rover_reg;
    logic [SIZE_WIDTH-1:0] req_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      left_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [SIZE_WIDTH-1:0] pick_size_reg;
    logic                  granted_reg;
    logic [IDX_FIELD_W-1:0] chosen_reg;

    logic [31:0]           cnt_full;
    logic [31:0]           idx_ext;
    logic [31:0]           size_ext;
    logic [31:0]           req_ext;
    logic [31:0]           pos_inc;
    logic [31:0]           pick_ext;
    logic [IDX_W-1:0]      start_pos;
    logic [IDX_W-1:0]      nxt_pos;
    logic [IDX_W-1:0]      raddr;
    logic                  load_in_range;
    logic                  fits;
    logic                  take;
    logic                  mem_we;
    logic [IDX_W-1:0]      waddr;
    logic [SIZE_WIDTH-1:0] wdata;

    // Clamp the count in use to the table depth
    assign cnt_full = (32'(bcount_reg) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS)
                                                          : 32'(bcount_reg);

    // Fit the stream fields to the table geometry
    assign idx_ext       = 32'(in_block_index);
    assign size_ext      = 32'(in_block_size);
    assign req_ext       = 32'(in_request_size);
    assign load_in_range = idx_ext < 32'(NUM_BLOCKS);

    // Next fit starts at the rover, or entry zero when the rover is not below the count;
    // the other rules always scan up from entry zero
    assign start_pos = (mode_reg == MODE_NEXT && 32'(rover_reg) < 32'(cnt_reg)) ? rover_reg
                                                                                : '0;
    assign pos_inc   = 32'(pos_reg) + 32'd1;
    assign nxt_pos   = (pos_inc == 32'(cnt_reg)) ? '0 : pos_inc[IDX_W-1:0];
    assign raddr     = cmd.scan_init ? start_pos : nxt_pos;

    assign status.cnt_zero  = cnt_reg == '0;
    assign status.scan_last = left_reg == CNT_W'(1);

    // Compare the entry read last cycle against the request
    assign fits = rd_data_reg >= req_reg;
    always_comb begin
        case (mode_reg)
            MODE_BEST:  take = fits && (!found_reg || pick_size_reg > rd_data_reg);
            MODE_WORST: take = fits && (!found_reg || pick_size_reg <= rd_data_reg);
            MODE_FIRST: take = fits && !found_reg;
            MODE_NEXT:  take = fits && !found_reg;
            default:    take = 1'b0;
        endcase
    end

    // Table write: loads and write-back never share a cycle
    assign mem_we = (cmd.load_we && load_in_range) || (cmd.wb_fire && found_reg);
    assign waddr  = cmd.load_we ? idx_ext[IDX_W-1:0] : pick_reg;
    assign wdata  = cmd.load_we ? size_ext[SIZE_WIDTH-1:0] : pick_size_reg - req_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // Config registers and rover
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_FIRST;
            bcount_reg <= BCOUNT_RESET;
            rover_reg  <= '0;
        end else begin
            if (cmd.cfg_we && cfg_index == REG_FIT_MODE) begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (cmd.cfg_we && cfg_index == REG_BLOCK_COUNT) begin
                bcount_reg <= cfg_data[BCOUNT_W-1:0];
            end
            if (cmd.wb_fire && found_reg && mode_reg == MODE_NEXT) begin
                rover_reg <= pick_reg;
            end
        end
    end

    // Capture the request, walk the table, track the pick
    always_ff @(posedge aclk) begin
        if (cmd.alloc_start) begin
            req_reg   <= req_ext[SIZE_WIDTH-1:0];
            cnt_reg   <= cnt_full[CNT_W-1:0];
            found_reg <= 1'b0;
        end
        if (cmd.scan_init) begin
            pos_reg  <= start_pos;
            left_reg <= cnt_reg;
        end
        if (cmd.scan_step) begin
            pos_reg  <= nxt_pos;
            left_reg <= left_reg - CNT_W'(1);
            if (take) begin
                found_reg     <= 1'b1;
                pick_reg      <= pos_reg;
                pick_size_reg <= rd_data_reg;
            end
        end
    end

    // Result word
    assign pick_ext = 32'(pick_reg);
    always_ff @(posedge aclk) begin
        if (cmd.wb_fire) begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? pick_ext[IDX_FIELD_W-1:0] : '0;
        end
    end

    assign out_granted      = granted_reg;
    assign out_chosen_block = chosen_reg;

endmodule

>>> hw/rtl/pfa_checker.sv
// Port-level checker for the partition fit allocator, bound to the top level.
// Depends on pfa_pkg and partition_fit_allocator_top.
module pfa_checker
    import pfa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // An allocate word blocks the input while the scan runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_ALLOC |=> !s_axis_tready)
        else $error("input taken right after an allocate word");

    // A refused request reports block zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == 1'b0 |-> m_axis_tdata == '0)
        else $error("refused result carries a nonzero block");

    // No result appears in the cycle after a word is taken from an empty output
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
